### rtl/bmcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcc_pkg: shared types and constants for the binary map corner classifier
// Word layouts, dimension constants and the weighted-sum corner codes.
// ----------------------------------------------------------------------------
package bmcc_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned CfgW      = 11;
  localparam int unsigned PixW      = 8;
  localparam int unsigned OutPosW   = 10;
  localparam int unsigned SumW      = 5;

  localparam logic [PixW-1:0]     PixOccupied = PixW'(255);
  localparam logic [CfgW-1:0]     WidthReset  = CfgW'(1024);
  localparam logic [CfgW-1:0]     WidthMin    = CfgW'(2);
  localparam logic [CfgW-1:0]     WidthMax    = CfgW'(MaxWidth);
  localparam logic [RowW-1:0]     RowLast     = RowW'(MaxHeight - 1);

  localparam logic [SumW-1:0] SumOuterPp = SumW'(15);
  localparam logic [SumW-1:0] SumOuterNp = SumW'(13);
  localparam logic [SumW-1:0] SumOuterPn = SumW'(9);
  localparam logic [SumW-1:0] SumOuterNn = SumW'(11);
  localparam logic [SumW-1:0] SumInnerPp = SumW'(5);
  localparam logic [SumW-1:0] SumInnerNp = SumW'(7);
  localparam logic [SumW-1:0] SumInnerPn = SumW'(3);
  localparam logic [SumW-1:0] SumInnerNn = SumW'(1);

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } in_word_t;

  typedef struct packed {
    logic [OutPosW-1:0] corner_x;
    logic [OutPosW-1:0] corner_y;
    logic               dir_x_negative;
    logic               dir_y_negative;
    logic               inner_corner;
  } out_word_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            occ;
  } pos_t;

endpackage

### rtl/binary_map_corner_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_map_corner_classifier: 2x2 window corner detection on a binary map
// Binarizes raster map pixels and reports outer and inner corners.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one pixel word
//   per cycle in raster order; frame_start marks the first pixel of a map.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives at most one
//   corner word per pixel, in pixel order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the row
//   width; write it only while no pixel is in flight.
//   Each pixel passes the window-stage register, then the output register.
//   Throughput: one pixel per unstalled cycle, set by the single line-buffer
//   read and write per pixel (one read port, one write port of the line RAM).
//   Reset clears the counters, window bits and valid flags and sets the
//   width to 1024; the line RAM is not cleared, the first row ignores it.
//   When the receiver stalls, the held word stays put, at most one more pixel
//   enters the window stage and then in_stall_o rises until the word leaves.
// ----------------------------------------------------------------------------
module binary_map_corner_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bmcc_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bmcc_pkg::out_word_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bmcc_pkg::CfgW-1:0]    cfg_data_i
);

  logic                      accept;
  logic                      busy;
  bmcc_pkg::pos_t            pos;
  logic                      above;
  logic                      wr_en;
  logic [bmcc_pkg::ColW-1:0] wr_addr;
  logic                      wr_bit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;

  bmcc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .pos_o      (pos)
  );

  bmcc_ram #(
    .Width (1),
    .Depth (bmcc_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_bit),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (above)
  );

  bmcc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pos_i       (pos),
    .above_i     (above),
    .busy_o      (busy),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_bit_o    (wr_bit),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/bmcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmcc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bmcc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcc_scan: raster position tracking
// Holds the width register and the column and row counters, and gives the
// position and occupied bit of the incoming pixel.
// ----------------------------------------------------------------------------
module bmcc_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bmcc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         accept_i,
  input  bmcc_pkg::in_word_t           in_data_i,
  output bmcc_pkg::pos_t               pos_o
);

  logic [bmcc_pkg::CfgW-1:0] width_q;
  logic [bmcc_pkg::CfgW-1:0] width_used;
  logic [bmcc_pkg::ColW-1:0] col_q, col_d, col_cur;
  logic [bmcc_pkg::RowW-1:0] row_q, row_d, row_cur;
  logic [bmcc_pkg::CfgW-1:0] col_inc;
  logic                      wrap;

  always_comb begin
    if (width_q < bmcc_pkg::WidthMin) begin
      width_used = bmcc_pkg::WidthMin;
    end else if (width_q > bmcc_pkg::WidthMax) begin
      width_used = bmcc_pkg::WidthMax;
    end else begin
      width_used = width_q;
    end
  end

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    if (bmcc_pkg::CfgW'(col_cur) >= width_used) begin
      col_cur = '0;
    end
    col_inc = bmcc_pkg::CfgW'(col_cur) + bmcc_pkg::CfgW'(1);
    wrap    = (col_inc >= width_used);
    col_d   = wrap ? '0 : col_inc[bmcc_pkg::ColW-1:0];
    row_d   = (wrap && (row_cur != bmcc_pkg::RowLast)) ? row_cur + bmcc_pkg::RowW'(1)
                                                       : row_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= bmcc_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col = col_cur;
  assign pos_o.row = row_cur;
  assign pos_o.occ = (in_data_i.pixel == bmcc_pkg::PixOccupied);

endmodule

### rtl/bmcc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcc_classify: window stage and output register
// Combines the line-buffer bit with the window bits, classifies the 2x2
// window and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module bmcc_classify (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  bmcc_pkg::pos_t               pos_i,
  input  logic                         above_i,
  output logic                         busy_o,
  output logic                         wr_en_o,
  output logic [bmcc_pkg::ColW-1:0]    wr_addr_o,
  output logic                         wr_bit_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bmcc_pkg::out_word_t          out_data_o
);

  logic                      s1_valid_q;
  bmcc_pkg::pos_t            s1_pos_q;
  logic                      left_q, upper_left_q;
  logic                      out_valid_q, out_valid_d;
  bmcc_pkg::out_word_t       out_q, out_d;
  logic                      advance;
  logic [bmcc_pkg::SumW-1:0] sum;
  logic                      hit, inner, xneg, yneg;

  assign advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign busy_o  = s1_valid_q && !advance;

  assign sum = bmcc_pkg::SumW'(upper_left_q)
             + bmcc_pkg::SumW'(3) * bmcc_pkg::SumW'(above_i)
             + bmcc_pkg::SumW'(7) * bmcc_pkg::SumW'(left_q)
             + bmcc_pkg::SumW'(5) * bmcc_pkg::SumW'(s1_pos_q.occ);

  always_comb begin
    hit   = 1'b1;
    inner = 1'b0;
    xneg  = 1'b0;
    yneg  = 1'b0;
    case (sum)
      bmcc_pkg::SumOuterPp: begin
      end
      bmcc_pkg::SumOuterNp: begin
        xneg = 1'b1;
      end
      bmcc_pkg::SumOuterPn: begin
        yneg = 1'b1;
      end
      bmcc_pkg::SumOuterNn: begin
        xneg = 1'b1;
        yneg = 1'b1;
      end
      bmcc_pkg::SumInnerPp: begin
        inner = 1'b1;
      end
      bmcc_pkg::SumInnerNp: begin
        inner = 1'b1;
        xneg  = 1'b1;
      end
      bmcc_pkg::SumInnerPn: begin
        inner = 1'b1;
        yneg  = 1'b1;
      end
      bmcc_pkg::SumInnerNn: begin
        inner = 1'b1;
        xneg  = 1'b1;
        yneg  = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if ((s1_pos_q.col == '0) || (s1_pos_q.row == '0)) begin
      hit = 1'b0;
    end
  end

  always_comb begin
    out_d.corner_x       = bmcc_pkg::OutPosW'(xneg ? s1_pos_q.col - bmcc_pkg::ColW'(1)
                                                   : s1_pos_q.col);
    out_d.corner_y       = bmcc_pkg::OutPosW'(yneg ? s1_pos_q.row - bmcc_pkg::RowW'(1)
                                                   : s1_pos_q.row);
    out_d.dir_x_negative = xneg;
    out_d.dir_y_negative = yneg;
    out_d.inner_corner   = inner;
    if (advance && hit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      left_q       <= 1'b0;
      upper_left_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        left_q       <= s1_pos_q.occ;
        upper_left_q <= above_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pos_q <= pos_i;
    end
    if (advance && hit) begin
      out_q <= out_d;
    end
  end

  assign wr_en_o     = advance;
  assign wr_addr_o   = s1_pos_q.col;
  assign wr_bit_o    = s1_pos_q.occ;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/binary_map_corner_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_map_corner_classifier_tb: self-checking bench for the corner finder
// Streams raster map pixels over several row widths and checks every corner
// word against an in-bench window classifier. Covers short directed rows,
// random frames and restarts, clamped widths, a long receiver hold-off and
// random idling on both channels.
// ----------------------------------------------------------------------------
module binary_map_corner_classifier_tb;

  localparam int unsigned HoldCycles = 90;

  typedef enum logic [1:0] {
    CornerPredicted,
    CornerNone,
    CornerTyped
  } corner_src_e;

  typedef struct packed {
    corner_src_e         src;
    bmcc_pkg::out_word_t word;
  } corner_note_t;

  typedef struct packed {
    logic [bmcc_pkg::PixW-1:0] pixel;
    logic                      frame_start;
    corner_src_e               src;
    bmcc_pkg::out_word_t       word;
  } pixel_row_t;

  // width 2: two pixels per row, one full window per row from row 1 on
  localparam pixel_row_t DirTable [24] = '{
    '{8'd255, 1'b1, CornerNone,      '0},
    '{8'd255, 1'b0, CornerNone,      '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd254, 1'b0, CornerTyped,     '{10'd0, 10'd0, 1'b1, 1'b1, 1'b0}},
    '{8'd0,   1'b0, CornerPredicted, '0},
    '{8'd0,   1'b0, CornerPredicted, '0},
    '{8'd128, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd127, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd1,   1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd64,  1'b0, CornerPredicted, '0},
    '{8'd254, 1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd0,   1'b0, CornerPredicted, '0},
    '{8'd0,   1'b0, CornerPredicted, '0},
    '{8'd255, 1'b0, CornerPredicted, '0},
    '{8'd254, 1'b0, CornerPredicted, '0},
    '{8'd200, 1'b0, CornerPredicted, '0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  bmcc_pkg::in_word_t        in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  bmcc_pkg::out_word_t       out_data_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [bmcc_pkg::CfgW-1:0] cfg_data_i;

  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 73;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  corner_note_t        pixel_notes[$];
  bmcc_pkg::out_word_t expected_corners[$];
  int unsigned         pixels_taken = 0;
  int unsigned         corners_checked = 0;
  int unsigned         items_sent = 0;
  int unsigned         mismatches = 0;

  // classifier state
  bit                        line_bits [bmcc_pkg::MaxWidth];
  bit                        win_left = 1'b0;
  bit                        win_upleft = 1'b0;
  int unsigned               px_col = 0;
  int unsigned               px_row = 0;
  logic [bmcc_pkg::CfgW-1:0] width_reg = bmcc_pkg::WidthReset;

  binary_map_corner_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned active_width(input logic [bmcc_pkg::CfgW-1:0] v);
    if (v < bmcc_pkg::WidthMin) return int'(bmcc_pkg::WidthMin);
    if (v > bmcc_pkg::WidthMax) return int'(bmcc_pkg::WidthMax);
    return int'(v);
  endfunction

  function automatic bit classify_pixel(input bmcc_pkg::in_word_t w,
                                        output bmcc_pkg::out_word_t res);
    bit                        occ;
    bit                        above;
    bit                        hit;
    bit                        xn;
    bit                        yn;
    bit                        inn;
    int unsigned               wdt;
    int unsigned               c;
    int unsigned               r;
    int                        sum_i;
    logic [bmcc_pkg::SumW-1:0] s;
    occ = (w.pixel == bmcc_pkg::PixOccupied);
    if (w.frame_start) begin
      px_col = 0;
      px_row = 0;
    end
    wdt = active_width(width_reg);
    if (px_col >= wdt) px_col = 0;
    c = px_col;
    r = px_row;
    above = line_bits[c];
    hit = 1'b0;
    xn = 1'b0;
    yn = 1'b0;
    inn = 1'b0;
    res = '0;
    if (r >= 1 && c >= 1) begin
      sum_i = int'(win_upleft) + 3 * int'(above) + 7 * int'(win_left) + 5 * int'(occ);
      s = bmcc_pkg::SumW'(sum_i);
      hit = 1'b1;
      case (s)
        bmcc_pkg::SumOuterPp: ;
        bmcc_pkg::SumOuterNp: xn = 1'b1;
        bmcc_pkg::SumOuterPn: yn = 1'b1;
        bmcc_pkg::SumOuterNn: begin
          xn = 1'b1;
          yn = 1'b1;
        end
        bmcc_pkg::SumInnerPp: inn = 1'b1;
        bmcc_pkg::SumInnerNp: begin
          inn = 1'b1;
          xn = 1'b1;
        end
        bmcc_pkg::SumInnerPn: begin
          inn = 1'b1;
          yn = 1'b1;
        end
        bmcc_pkg::SumInnerNn: begin
          inn = 1'b1;
          xn = 1'b1;
          yn = 1'b1;
        end
        default: hit = 1'b0;
      endcase
      if (hit) begin
        res.corner_x       = bmcc_pkg::OutPosW'(xn ? c - 1 : c);
        res.corner_y       = bmcc_pkg::OutPosW'(yn ? r - 1 : r);
        res.dir_x_negative = xn;
        res.dir_y_negative = yn;
        res.inner_corner   = inn;
      end
    end
    win_upleft = above;
    line_bits[c] = occ;
    win_left = occ;
    px_col = c + 1;
    if (px_col >= wdt) begin
      px_col = 0;
      if (px_row < bmcc_pkg::MaxHeight - 1) px_row++;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_corner(input bmcc_pkg::out_word_t got);
    bmcc_pkg::out_word_t want;
    if (expected_corners.size() == 0) begin
      report_mismatch($sformatf("corner word x=%0d y=%0d with none expected",
                                got.corner_x, got.corner_y));
    end else begin
      want = expected_corners.pop_front();
      corners_checked++;
      if (got.corner_x !== want.corner_x)
        report_mismatch($sformatf("corner_x got %0d want %0d", got.corner_x, want.corner_x));
      if (got.corner_y !== want.corner_y)
        report_mismatch($sformatf("corner_y got %0d want %0d", got.corner_y, want.corner_y));
      if (got.dir_x_negative !== want.dir_x_negative)
        report_mismatch($sformatf("dir_x_negative got %b want %b at (%0d,%0d)",
                                  got.dir_x_negative, want.dir_x_negative,
                                  want.corner_x, want.corner_y));
      if (got.dir_y_negative !== want.dir_y_negative)
        report_mismatch($sformatf("dir_y_negative got %b want %b at (%0d,%0d)",
                                  got.dir_y_negative, want.dir_y_negative,
                                  want.corner_x, want.corner_y));
      if (got.inner_corner !== want.inner_corner)
        report_mismatch($sformatf("inner_corner got %b want %b at (%0d,%0d)",
                                  got.inner_corner, want.inner_corner,
                                  want.corner_x, want.corner_y));
    end
  endtask

  always @(posedge clk_i) begin : watch
    corner_note_t        note;
    bmcc_pkg::out_word_t word;
    bit                  hit;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) width_reg = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        note = pixel_notes.pop_front();
        hit = classify_pixel(in_data_i, word);
        pixels_taken++;
        case (note.src)
          CornerPredicted: if (hit) expected_corners = {expected_corners, word};
          CornerTyped:     expected_corners = {expected_corners, note.word};
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) check_corner(out_data_o);
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [bmcc_pkg::PixW-1:0] pick_pixel(input int unsigned occ_pct);
    if ($urandom_range(99) < occ_pct) return bmcc_pkg::PixOccupied;
    case ($urandom_range(3))
      0: return '0;
      1: return bmcc_pkg::PixOccupied - bmcc_pkg::PixW'(1);
      default: return bmcc_pkg::PixW'($urandom_range(0, 254));
    endcase
  endfunction

  task automatic drive_pixel(input logic [bmcc_pkg::PixW-1:0] pix, input logic fs,
                             input corner_src_e src, input bmcc_pkg::out_word_t word);
    corner_note_t note;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    note.src = src;
    note.word = word;
    pixel_notes = {pixel_notes, note};
    in_data_i <= bmcc_pkg::in_word_t'{pixel: pix, frame_start: fs};
    in_valid_i <= 1'b1;
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_corners.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [bmcc_pkg::CfgW-1:0] v);
    wait_drained();
    // let a pixel with no corner clear the pipeline
    repeat (4) @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned count, input bit with_start,
                            input int unsigned occ_pct);
    for (int unsigned i = 0; i < count; i++)
      drive_pixel(pick_pixel(occ_pct), with_start && (i == 0), CornerPredicted, '0);
  endtask

  task automatic run_random_phase(input int unsigned target);
    logic [bmcc_pkg::CfgW-1:0] v;
    int unsigned               w;
    int unsigned               frames;
    int unsigned               len;
    case ($urandom_range(9))
      0: v = '0;
      1: v = bmcc_pkg::CfgW'(1);
      2: v = bmcc_pkg::CfgW'(3);
      default: v = bmcc_pkg::CfgW'($urandom_range(2, 24));
    endcase
    write_width(v);
    w = active_width(v);
    frames = $urandom_range(2, 5);
    for (int unsigned f = 0; f < frames && items_sent < target; f++) begin
      len = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
      // cut some frames short so the next restart lands mid-row
      if ($urandom_range(5) == 0) len = $urandom_range(1, len);
      if (len > target - items_sent) len = target - items_sent;
      send_frame(len, (f == 0) || ($urandom_range(7) != 0), $urandom_range(15, 85));
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_width(bmcc_pkg::CfgW'(2));
    foreach (DirTable[i])
      drive_pixel(DirTable[i].pixel, DirTable[i].frame_start, DirTable[i].src,
                  DirTable[i].word);

    // hold the receiver off while pixels keep coming
    write_width(bmcc_pkg::CfgW'(5));
    send_frame(8, 1'b1, 50);
    hold_req <= 1'b1;
    send_frame(40, 1'b0, 50);

    while (items_sent < 420) run_random_phase(420);

    tx_idle_pct <= 73;
    rx_idle_pct <= 23;
    // clamped width, paused mid-frame until every corner is out
    write_width(bmcc_pkg::CfgW'(1));
    send_frame(60, 1'b1, 45);
    wait_drained();
    send_frame(60, 1'b0, 45);
    while (items_sent < 840) run_random_phase(840);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    while (items_sent < 1250) run_random_phase(1250);

    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_corners.size() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (expected_corners.size() != 0)
      report_mismatch($sformatf("%0d corner words never arrived", expected_corners.size()));

    $display("Run covered %0d pixels and %0d corner words at row widths 2 to 24,",
             pixels_taken, corners_checked);
    $display("clamped widths, mid-row restarts, a long output hold-off and idling.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: handshakes stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
